// ===== rtl/core/mtbd_pkg.sv =====
// Package: shared types and constants for the bounded MT19937 draw block.
package mtbd_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned SHIFT_WORDS = 397;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ADDR_W = 10;

  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] TWIST_CONST = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C = 32'hEFC6_0000;
  localparam logic [31:0] SEED_MULT = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'h0000_1105;

  localparam logic [IDX_W-1:0] IDX_USED_UP = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_NEVER_SEEDED = IDX_W'(STATE_WORDS + 1);

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    CMD_SEED,
    CMD_DRAW,
    CMD_ZERO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] seed;
    logic [15:0] bound;
    logic [15:0] mask;
  } cmd_t;

  function automatic logic [31:0] twist_pair(logic [31:0] hi_word, logic [31:0] lo_word);
    logic [31:0] y;
    y = (hi_word & UPPER_MASK) | (lo_word & LOWER_MASK);
    return (y >> 1) ^ (y[0] ? TWIST_CONST : 32'h0);
  endfunction

  function automatic logic [31:0] temper(logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [15:0] bound_mask(logic [15:0] b);
    logic [15:0] m;
    m = b;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

endpackage

// ===== rtl/core/mtbd_front.sv =====
// Front part: accept input transactions, classify them and queue commands.
module mtbd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [31:0]          in_seed_value,
  input  logic [15:0]          in_bound,
  output logic                 cmd_valid,
  input  logic                 cmd_take,
  output mtbd_pkg::cmd_t       cmd
);

  mtbd_pkg::cmd_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  mtbd_pkg::cmd_t c_new;
  logic           push;

  always_comb begin
    c_new.seed = in_seed_value;
    c_new.bound = in_bound;
    c_new.mask = mtbd_pkg::bound_mask(in_bound);
    if (in_operation == mtbd_pkg::OP_SEED) begin
      c_new.kind = mtbd_pkg::CMD_SEED;
    end else if (in_bound == 16'd0) begin
      c_new.kind = mtbd_pkg::CMD_ZERO;
    end else begin
      c_new.kind = mtbd_pkg::CMD_DRAW;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c_new;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (cmd_take) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_take};
    end
  end

endmodule

// ===== rtl/core/mtbd_back.sv =====
// Back part: seeding, regeneration and bounded draws from the word memory.
module mtbd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  mtbd_pkg::cmd_t       cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_value,
  output logic                 out_bound_error
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_GEN_RD0,
    S_GEN_RD1,
    S_GEN_RD2,
    S_GEN_WR,
    S_DRAW_RD,
    S_DRAW_WAIT,
    S_DRAW_CHK,
    S_OUT
  } state_t;

  logic [31:0] mem [mtbd_pkg::STATE_WORDS];
  logic [31:0] rdata_r;
  logic [mtbd_pkg::ADDR_W-1:0] raddr;
  logic        we;
  logic [mtbd_pkg::ADDR_W-1:0] waddr;
  logic [31:0] wdata;

  state_t      state_r;
  logic [mtbd_pkg::IDX_W-1:0] idx_r;
  logic [mtbd_pkg::ADDR_W-1:0] k_r;
  logic [31:0] word_r;
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic [31:0] temp_r;
  logic        draw_pend_r;
  mtbd_pkg::cmd_t cur_r;
  logic [15:0] val_r;
  logic        err_r;
  logic [mtbd_pkg::ADDR_W-1:0] k_next;
  logic [mtbd_pkg::ADDR_W-1:0] k_far;
  logic [15:0] masked;

  always_comb begin
    k_next = (k_r == mtbd_pkg::ADDR_W'(mtbd_pkg::STATE_WORDS - 1)) ? '0 : k_r + 1'b1;
    if (k_r >= mtbd_pkg::ADDR_W'(mtbd_pkg::STATE_WORDS - mtbd_pkg::SHIFT_WORDS)) begin
      k_far = k_r - mtbd_pkg::ADDR_W'(mtbd_pkg::STATE_WORDS - mtbd_pkg::SHIFT_WORDS);
    end else begin
      k_far = k_r + mtbd_pkg::ADDR_W'(mtbd_pkg::SHIFT_WORDS);
    end
    masked = temp_r[15:0] & cur_r.mask;
  end

  always_comb begin
    raddr = k_r;
    we = 1'b0;
    waddr = k_r;
    wdata = word_r;
    case (state_r)
      S_SEED: begin
        we = 1'b1;
      end
      S_GEN_RD0: raddr = k_r;
      S_GEN_RD1: raddr = k_next;
      S_GEN_RD2: raddr = k_far;
      S_GEN_WR: begin
        we = 1'b1;
        wdata = rdata_r ^ mtbd_pkg::twist_pair(hi_r, lo_r);
      end
      S_DRAW_RD: raddr = idx_r[mtbd_pkg::ADDR_W-1:0];
      default: raddr = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = (state_r == S_OUT);
  assign out_value = val_r;
  assign out_bound_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= mtbd_pkg::IDX_NEVER_SEEDED;
      k_r <= '0;
      draw_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            case (cmd.kind)
              mtbd_pkg::CMD_SEED: begin
                k_r <= '0;
                word_r <= cmd.seed;
                draw_pend_r <= 1'b0;
                state_r <= S_SEED;
              end
              mtbd_pkg::CMD_ZERO: begin
                val_r <= '0;
                err_r <= 1'b1;
                state_r <= S_OUT;
              end
              default: begin
                state_r <= S_DRAW_RD;
              end
            endcase
          end
        end
        S_SEED: begin
          word_r <= word_r * mtbd_pkg::SEED_MULT;
          if (k_r == mtbd_pkg::ADDR_W'(mtbd_pkg::STATE_WORDS - 1)) begin
            k_r <= '0;
            idx_r <= mtbd_pkg::IDX_USED_UP;
            state_r <= draw_pend_r ? S_GEN_RD0 : S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_GEN_RD0: state_r <= S_GEN_RD1;
        S_GEN_RD1: begin
          hi_r <= rdata_r;
          state_r <= S_GEN_RD2;
        end
        S_GEN_RD2: begin
          lo_r <= rdata_r;
          state_r <= S_GEN_WR;
        end
        S_GEN_WR: begin
          if (k_r == mtbd_pkg::ADDR_W'(mtbd_pkg::STATE_WORDS - 1)) begin
            k_r <= '0;
            idx_r <= '0;
            state_r <= S_DRAW_RD;
          end else begin
            k_r <= k_next;
            state_r <= S_GEN_RD0;
          end
        end
        S_DRAW_RD: begin
          if (idx_r == mtbd_pkg::IDX_NEVER_SEEDED) begin
            k_r <= '0;
            word_r <= mtbd_pkg::DEFAULT_SEED;
            draw_pend_r <= 1'b1;
            state_r <= S_SEED;
          end else if (idx_r == mtbd_pkg::IDX_USED_UP) begin
            k_r <= '0;
            state_r <= S_GEN_RD0;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_DRAW_WAIT;
          end
        end
        S_DRAW_WAIT: begin
          temp_r <= mtbd_pkg::temper(rdata_r);
          state_r <= S_DRAW_CHK;
        end
        S_DRAW_CHK: begin
          if (masked < cur_r.bound) begin
            val_r <= masked;
            err_r <= 1'b0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DRAW_RD;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/mersenne_twister_bounded_draw.sv =====
// Top level: bounded random draws from an MT19937 generator.
//   channel | ports                                         | direction
//   in      | in_valid in_stall in_operation in_seed_value in_bound | input
//   out     | out_valid out_stall out_value out_bound_error | output
// A draw is dispatched, then each tried word is read, tempered and checked, then the result is output.
// Regeneration reads three words and writes one for each word, through the single read port of the word memory.
// Reseed writes one word a cycle. A zero bound answers with a zero value and out_bound_error set.
// Reset leaves the generator unseeded; the first draw with a nonzero bound seeds with 4357.
// A two-entry command queue keeps accepting, until it is full, while a result waits on out_stall.
module mersenne_twister_bounded_draw (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_seed_value,
  input  logic [15:0] in_bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_value,
  output logic        out_bound_error
);

  logic           cmd_valid;
  logic           cmd_take;
  mtbd_pkg::cmd_t cmd;

  mtbd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_seed_value(in_seed_value), .in_bound(in_bound),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  mtbd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_bound_error(out_bound_error)
  );

endmodule

// ===== test/tb_mersenne_twister_bounded_draw.sv =====
// Testbench: MT19937 bounded draw block checked against an in-bench generator predictor.
module tb_mersenne_twister_bounded_draw;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [15:0] value;
    logic        bound_error;
  } draw_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [31:0] in_seed_value;
  logic [15:0] in_bound;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_value;
  logic        out_bound_error;

  logic [31:0]  gen_words [mtbd_pkg::STATE_WORDS];
  int unsigned  gen_index;
  draw_result_t expected_draws [$];
  int unsigned  mismatch_count;
  int unsigned  draw_count;
  int unsigned  seed_count;
  int unsigned  zero_count;
  int unsigned  idle_cycles;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  bit           timed_out;

  mersenne_twister_bounded_draw u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_seed_value(in_seed_value), .in_bound(in_bound),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_bound_error(out_bound_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void gen_seed(logic [31:0] s);
    gen_words[0] = s;
    for (int i = 1; i < mtbd_pkg::STATE_WORDS; i++) begin
      gen_words[i] = gen_words[i-1] * 32'd69069;
    end
    gen_index = mtbd_pkg::STATE_WORDS;
  endfunction

  function automatic void gen_regenerate();
    logic [31:0] y;
    for (int k = 0; k < mtbd_pkg::STATE_WORDS; k++) begin
      y = {gen_words[k][31], gen_words[(k + 1) % mtbd_pkg::STATE_WORDS][30:0]};
      gen_words[k] = gen_words[(k + mtbd_pkg::SHIFT_WORDS) % mtbd_pkg::STATE_WORDS]
                     ^ (y >> 1) ^ (y[0] ? 32'h9908_B0DF : 32'h0);
    end
    gen_index = 0;
  endfunction

  function automatic logic [31:0] gen_next_tempered();
    logic [31:0] y;
    if (gen_index >= mtbd_pkg::STATE_WORDS) begin
      if (gen_index != mtbd_pkg::STATE_WORDS) gen_seed(32'h0000_1105);
      gen_regenerate();
    end
    y = gen_words[gen_index];
    gen_index++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void predict_transaction(logic op, logic [31:0] s, logic [15:0] b);
    draw_result_t r;
    logic [15:0] m;
    logic [15:0] v;
    if (op == mtbd_pkg::OP_SEED) begin
      gen_seed(s);
      seed_count++;
      return;
    end
    r.bound_error = 1'b0;
    if (b == 16'd0) begin
      r.value = 16'd0;
      r.bound_error = 1'b1;
      zero_count++;
    end else begin
      m = 16'd0;
      for (int i = 0; i < 16; i++) begin
        if (b >> i) m[i] = 1'b1;
      end
      do begin
        v = gen_next_tempered() & m;
      end while (v >= b);
      r.value = v;
    end
    draw_count++;
    expected_draws.push_back(r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_transaction(logic op, logic [31:0] s, logic [15:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_seed_value <= s;
    in_bound <= b;
    do @(posedge clk); while (in_stall);
    predict_transaction(op, s, b);
  endtask

  // check results and drive receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("result with no draw pending");
        end else begin
          draw_result_t e;
          e = expected_draws.pop_front();
          if (out_value !== e.value)
            report_mismatch($sformatf("value %0d, expected %0d", out_value, e.value));
          if (out_bound_error !== e.bound_error)
            report_mismatch($sformatf("bound_error %0b, expected %0b",
                                      out_bound_error, e.bound_error));
        end
      end
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end
  end

  initial begin
    wait (timed_out);
    $display("watchdog expired with %0d draws pending", expected_draws.size());
    $display("tb_mersenne_twister_bounded_draw failed");
    $finish;
  end

  function automatic logic [15:0] random_bound();
    case ($urandom_range(5))
      0: return 16'($urandom_range(1, 3));
      1: return 16'($urandom_range(0, 255));
      2: return 16'h8000 | 16'($urandom_range(0, 15));
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic test_unseeded_draw();
    send_transaction(mtbd_pkg::OP_DRAW, 32'hFFFF_FFFF, 16'd0);
    send_transaction(mtbd_pkg::OP_DRAW, $urandom, 16'hFFFF);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd1);
  endtask

  task automatic test_directed();
    send_transaction(mtbd_pkg::OP_SEED, 32'h0, 16'hFFFF);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd1);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd2);
    send_transaction(mtbd_pkg::OP_SEED, 32'hFFFF_FFFF, 16'd0);
    send_transaction(mtbd_pkg::OP_DRAW, 32'hFFFF_FFFF, 16'hFFFF);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'h8000);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'h8001);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd0);
    send_transaction(mtbd_pkg::OP_SEED, 32'hAAAA_5555, 16'h5555);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h5555_AAAA, 16'hAAAA);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'h5555);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd3);
    send_transaction(mtbd_pkg::OP_SEED, 32'h0000_1105, 16'd7);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd0);
    send_transaction(mtbd_pkg::OP_DRAW, 32'h0, 16'd1000);
  endtask

  task automatic test_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0)
        send_transaction(mtbd_pkg::OP_SEED, $urandom, 16'($urandom));
      else if ($urandom_range(19) == 0)
        send_transaction(mtbd_pkg::OP_DRAW, $urandom, 16'd0);
      else
        send_transaction(mtbd_pkg::OP_DRAW, $urandom, random_bound());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = mtbd_pkg::OP_SEED;
    in_seed_value = 32'h0;
    in_bound = 16'h0;
    mismatch_count = 0;
    draw_count = 0;
    seed_count = 0;
    zero_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_index = mtbd_pkg::STATE_WORDS + 1;
    foreach (gen_words[i]) gen_words[i] = 32'h0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unseeded_draw();
    test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 88;
    test_random(450);
    send_idle_pct = 88;
    recv_idle_pct = 20;
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(480);
    drain();

    $display("covered %0d draws (%0d with zero bound) and %0d reseeds",
             draw_count, zero_count, seed_count);
    $display("idle patterns: sender/receiver 20/88, 88/20 and none");
    if (mismatch_count == 0 && expected_draws.size() == 0) begin
      $display("tb_mersenne_twister_bounded_draw passed");
    end else begin
      $display("%0d mismatches, %0d draws left", mismatch_count, expected_draws.size());
      $display("tb_mersenne_twister_bounded_draw failed");
    end
    $finish;
  end
endmodule
